### design/gcpp_pkg.sv
// ----------------------------------------------------------------------------
// gcpp_pkg
// Shared types and constants of the command packet parser.
// ----------------------------------------------------------------------------
package gcpp_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned COUNT_W = 11;

	localparam logic [ADDR_W-1:0] IB_BASE_RESET = 16'h0738;

	typedef enum logic [2:0] {
		KIND_T0   = 3'd0,
		KIND_T1   = 3'd1,
		KIND_T2   = 3'd2,
		KIND_T3   = 3'd3,
		KIND_ZERO = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SLOT_FIRST  = 2'd0,
		SLOT_SECOND = 2'd1,
		SLOT_EXTRA  = 2'd2
	} slot_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic [ADDR_W-1:0] addr;
	} wr_t;

endpackage

### design/gcpp_front.sv
// ----------------------------------------------------------------------------
// gcpp_front
// Accepts command words, decodes headers and turns data words into
// register writes for the queue.
// ----------------------------------------------------------------------------
module gcpp_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [gcpp_pkg::WORD_W-1:0]    s_tdata,
	input  logic                           s_tlast,
	input  logic                           q_full,
	output logic                           q_push,
	output gcpp_pkg::wr_t                  q_wdata
);

	logic [gcpp_pkg::COUNT_W-1:0] words_left_q;
	gcpp_pkg::kind_t              kind_q;
	logic [gcpp_pkg::ADDR_W-1:0]  next_reg_q;
	logic [12:0]                  second_reg_q;
	gcpp_pkg::slot_t              slot_q;

	logic accept;
	logic is_hdr;
	logic emit;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_hdr   = (words_left_q == '0);
	assign emit     = !is_hdr && ((kind_q == gcpp_pkg::KIND_T0) ||
		((kind_q == gcpp_pkg::KIND_T1) && (slot_q != gcpp_pkg::SLOT_EXTRA)));

	assign q_push        = accept && emit;
	assign q_wdata.value = s_tdata;
	assign q_wdata.addr  = ((kind_q == gcpp_pkg::KIND_T1) && (slot_q == gcpp_pkg::SLOT_SECOND))
		? {3'b000, second_reg_q} : next_reg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_left_q <= '0;
			kind_q       <= gcpp_pkg::KIND_T0;
			next_reg_q   <= '0;
			second_reg_q <= '0;
			slot_q       <= gcpp_pkg::SLOT_FIRST;
		end else if (accept) begin
			if (s_tlast) begin
				words_left_q <= '0;
			end else if (is_hdr) begin
				words_left_q <= {1'b0, s_tdata[25:16]} + 11'd1;
			end else begin
				words_left_q <= words_left_q - 11'd1;
			end
			if (is_hdr) begin
				slot_q <= gcpp_pkg::SLOT_FIRST;
				if (s_tdata == '0) begin
					kind_q       <= gcpp_pkg::KIND_ZERO;
					next_reg_q   <= '0;
					second_reg_q <= '0;
				end else if (s_tdata[31:30] == 2'd1) begin
					kind_q       <= gcpp_pkg::KIND_T1;
					next_reg_q   <= {3'b000, s_tdata[10:0], 2'b00};
					second_reg_q <= {s_tdata[21:11], 2'b00};
				end else begin
					kind_q       <= gcpp_pkg::kind_t'({1'b0, s_tdata[31:30]});
					next_reg_q   <= {1'b0, s_tdata[12:0], 2'b00};
					second_reg_q <= '0;
				end
			end else begin
				if (kind_q == gcpp_pkg::KIND_T0) begin
					next_reg_q <= next_reg_q + 16'd4;
				end else if (kind_q == gcpp_pkg::KIND_T1) begin
					if (slot_q == gcpp_pkg::SLOT_FIRST) begin
						slot_q <= gcpp_pkg::SLOT_SECOND;
					end else begin
						slot_q <= gcpp_pkg::SLOT_EXTRA;
					end
				end
			end
		end
	end

	a_last_ends_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (words_left_q == '0))
		else $error("tail word did not return parser to header");

	a_header_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_hdr) |-> !q_push)
		else $error("header word produced a register write");

endmodule

### design/gcpp_queue.sv
// ----------------------------------------------------------------------------
// gcpp_queue
// Short FIFO of register writes between parser and output stage.
// ----------------------------------------------------------------------------
module gcpp_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gcpp_pkg::wr_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output gcpp_pkg::wr_t rdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	gcpp_pkg::wr_t   mem_q [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_push_lost: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("write pushed into full queue");

endmodule

### design/gcpp_back.sv
// ----------------------------------------------------------------------------
// gcpp_back
// Drains the write queue into the output register and flags writes to the
// indirect-buffer base register.
// ----------------------------------------------------------------------------
module gcpp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [gcpp_pkg::ADDR_W-1:0]   cfg_wdata,
	input  logic                          q_empty,
	input  gcpp_pkg::wr_t                 q_rdata,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [47:0]                   m_tdata,
	output logic                          m_tuser
);

	logic [gcpp_pkg::ADDR_W-1:0] ib_base_q;
	logic                        valid_q;
	gcpp_pkg::wr_t               wr_q;
	logic                        ib_q;

	assign q_pop    = !q_empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = {wr_q.value, wr_q.addr};
	assign m_tuser  = ib_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ib_base_q <= gcpp_pkg::IB_BASE_RESET;
			valid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				ib_base_q <= cfg_wdata;
			end
			if (q_pop) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			wr_q <= q_rdata;
			ib_q <= (q_rdata.addr == ib_base_q);
		end
	end

endmodule

### design/gpu_command_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// gpu_command_packet_parser_unit
// Command-word packet parser emitting register writes.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata[31:0] word, s_tlast last_word
// m_       out  m_tvalid/m_tready  m_tdata addr/value, m_tuser ib_base_write
// cfg_     in   cfg_wen            cfg_wdata ib_base_reg
//
// One word per cycle while not stalled; a write is queued, then registered.
// The front stalls only when the write queue (QUEUE_DEPTH) is full.
// Reset is asynchronous; the parser then expects a header.
// The output register drains the queue every cycle m_tready allows.
// ----------------------------------------------------------------------------
module gpu_command_packet_parser_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] word
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] reg_addr, [47:16] reg_value
	output logic        m_tuser,   // [0] ib_base_write
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata
);

	logic          q_full;
	logic          q_push;
	logic          q_empty;
	logic          q_pop;
	gcpp_pkg::wr_t q_wdata;
	gcpp_pkg::wr_t q_rdata;

	gcpp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	gcpp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	gcpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### test/gpu_command_packet_parser_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpu_command_packet_parser_unit_tb
// Streams command words through the parser and checks every register write.
// A table of directed words covers header extremes, each packet type, an
// all-zero header, short and long type-1 payloads and truncation by tlast.
// Random packets follow over several ib_base_reg settings and stall mixes;
// each write is checked against a local model of the parser.
// ----------------------------------------------------------------------------
module gpu_command_packet_parser_unit_tb;

	localparam int unsigned SETTLE      = 8;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned PHASE_WORDS = 170;
	localparam int unsigned PHASES      = 6;

	typedef struct packed {
		logic [15:0] addr;
		logic [31:0] value;
		logic        ib;
	} reg_write_t;

	typedef struct packed {
		logic [31:0] data;
		logic        tail;
		logic        typed;
		logic        has_wr;
		logic [15:0] addr;
		logic [31:0] value;
		logic        ib;
	} cmd_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;   // [31:0] word
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;          // [15:0] reg_addr, [47:16] reg_value
	logic        m_tuser;          // [0] ib_base_write
	logic        cfg_wen   = 1'b0;
	logic [15:0] cfg_wdata = '0;

	cmd_row_t    row_now   = '0;

	logic [10:0]     words_left = '0;
	gcpp_pkg::kind_t kind       = gcpp_pkg::KIND_T0;
	logic [15:0]     next_reg   = '0;
	logic [12:0]     second_reg = '0;
	gcpp_pkg::slot_t slot       = gcpp_pkg::SLOT_FIRST;
	logic [15:0]     ib_base    = gcpp_pkg::IB_BASE_RESET;

	reg_write_t  pending_writes [$];
	int unsigned fails      = 0;
	int unsigned quiet      = 0;
	int unsigned words_sent = 0;
	int unsigned send_idle  = 0;
	int unsigned recv_stall = 0;

	cmd_row_t cmd_rows [27] = '{
		'{32'h0000_01CE, 1'b0, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 16'h0738, 32'hFFFF_FFFF, 1'b1},
		'{32'h0001_1FFF, 1'b0, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b1, 1'b1, 16'h7FFC, 32'h0000_0000, 1'b0},
		'{32'hA5A5_5A5A, 1'b0, 1'b1, 1'b1, 16'h8000, 32'hA5A5_5A5A, 1'b0},
		'{32'h4002_FFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h1111_1111, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h2222_2222, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h3333_3333, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h4000_0123, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h4444_4444, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h8001_1234, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h5555_5555, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h6666_6666, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'hC000_FFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h1234_5678, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h0003_0010, 1'b1, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h03FF_01CE, 1'b0, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'hDEAD_BEEF, 1'b0, 1'b1, 1'b1, 16'h0738, 32'hDEAD_BEEF, 1'b1},
		'{32'h0BAD_F00D, 1'b1, 1'b1, 1'b1, 16'h073C, 32'h0BAD_F00D, 1'b0},
		'{32'h0400_0000, 1'b0, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b1, 1'b1, 16'h0000, 32'h0000_0001, 1'b0},
		'{32'h4001_0002, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h7777_7777, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
		'{32'h8888_8888, 1'b1, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0}
	};

	gpu_command_packet_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic parse_word(input logic [31:0] w, input logic tail,
			output reg_write_t wr);
		logic            hit;
		gcpp_pkg::kind_t hdr_kind;
		hit = 1'b0;
		wr = '0;
		hdr_kind = gcpp_pkg::kind_t'({1'b0, w[31:30]});
		if (words_left == '0) begin
			words_left = {1'b0, w[25:16]} + 11'd1;
			slot = gcpp_pkg::SLOT_FIRST;
			if (w == '0) begin
				kind = gcpp_pkg::KIND_ZERO;
				next_reg = '0;
				second_reg = '0;
			end else if (hdr_kind == gcpp_pkg::KIND_T1) begin
				kind = gcpp_pkg::KIND_T1;
				next_reg = {3'b000, w[10:0], 2'b00};
				second_reg = {w[21:11], 2'b00};
			end else begin
				kind = hdr_kind;
				next_reg = {1'b0, w[12:0], 2'b00};
				second_reg = '0;
			end
		end else begin
			case (kind)
				gcpp_pkg::KIND_T0: begin
					hit = 1'b1;
					wr.addr = next_reg;
					next_reg = next_reg + 16'd4;
				end
				gcpp_pkg::KIND_T1: begin
					if (slot == gcpp_pkg::SLOT_FIRST) begin
						hit = 1'b1;
						wr.addr = next_reg;
						slot = gcpp_pkg::SLOT_SECOND;
					end else if (slot == gcpp_pkg::SLOT_SECOND) begin
						hit = 1'b1;
						wr.addr = {3'b000, second_reg};
						slot = gcpp_pkg::SLOT_EXTRA;
					end
				end
				default: ;
			endcase
			words_left = words_left - 11'd1;
		end
		if (hit) begin
			wr.value = w;
			wr.ib = (wr.addr == ib_base);
		end
		if (tail)
			words_left = '0;
		return hit;
	endfunction

	always @(posedge clk) begin : monitor
		reg_write_t got;
		reg_write_t want;
		logic       hit;
		if (m_tvalid && m_tready) begin
			if (pending_writes.size() == 0) begin
				$error("write with none expected: reg_addr %h reg_value %h",
					m_tdata[15:0], m_tdata[47:16]);
				fails++;
			end else begin
				want = pending_writes.pop_front();
				if (m_tdata[15:0] !== want.addr) begin
					$error("reg_addr: expected %h, got %h", want.addr, m_tdata[15:0]);
					fails++;
				end
				if (m_tdata[47:16] !== want.value) begin
					$error("reg_value: expected %h, got %h", want.value, m_tdata[47:16]);
					fails++;
				end
				if (m_tuser !== want.ib) begin
					$error("ib_base_write: expected %b, got %b", want.ib, m_tuser);
					fails++;
				end
			end
		end
		if (s_tvalid && s_tready) begin
			hit = parse_word(s_tdata, s_tlast, got);
			if (row_now.typed) begin
				if (row_now.has_wr)
					pending_writes.push_back(
						reg_write_t'{row_now.addr, row_now.value, row_now.ib});
			end else if (hit) begin
				pending_writes.push_back(got);
			end
		end
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_wen)
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall);

	task automatic send_word(input cmd_row_t row);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= row.data;
		s_tlast <= row.tail;
		row_now <= row;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic wait_idle(input int unsigned settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_ib_base(input logic [15:0] v);
		wait_idle(SETTLE);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		ib_base = v;
	endtask

	task automatic send_packet();
		gcpp_pkg::kind_t pick;
		logic [31:0]     hdr;
		int unsigned     cnt;
		int unsigned     len;
		int unsigned     cut;
		cmd_row_t        row;
		row = '0;
		if ($urandom_range(99) < 12) begin
			row.data = $urandom;
			row.tail = ($urandom_range(9) == 0);
			send_word(row);
			return;
		end
		pick = gcpp_pkg::kind_t'($urandom_range(4));
		cnt = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(7);
		hdr = $urandom;
		hdr[25:16] = cnt[9:0];
		if (pick == gcpp_pkg::KIND_ZERO) begin
			hdr = '0;
		end else begin
			hdr[31:30] = 2'(pick);
			if ($urandom_range(1) == 1) begin
				if (pick == gcpp_pkg::KIND_T1)
					hdr[10:0] = ib_base[12:2];
				else
					hdr[12:0] = ib_base[14:2] - 13'($urandom_range(3));
			end
		end
		len = (hdr == '0) ? 1 : int'(hdr[25:16]) + 1;
		cut = (len > 8) ? $urandom_range(8, 1) : len;
		if ($urandom_range(9) == 0)
			cut = $urandom_range(cut);
		row.data = hdr;
		row.tail = (cut == 0);
		send_word(row);
		for (int unsigned i = 1; i <= cut; i++) begin
			if ($urandom_range(49) == 0)
				wait_idle(0);
			row.data = $urandom;
			row.tail = (i == cut) && (cut < len || $urandom_range(3) == 0);
			send_word(row);
		end
	endtask

	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int unsigned p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 78; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 78; end
				default: begin send_idle = 33; recv_stall = 33; end
			endcase
			case (p)
				0: ;
				1: write_ib_base(16'h0000);
				2: write_ib_base(16'hFFFF);
				3: write_ib_base(16'h7FFC);
				4: write_ib_base({14'($urandom_range(16'h1FFF)), 2'b00});
				default: write_ib_base(16'($urandom_range(16'hFFFF)));
			endcase
			if (p == 0) begin
				for (int i = 0; i < $size(cmd_rows); i++)
					send_word(cmd_rows[i]);
			end
			while (words_sent < (p + 1) * PHASE_WORDS)
				send_packet();
		end
		wait_idle(SETTLE);
		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
